### rtl/kvt_pkg.sv
// kvt_pkg: request and status codes, word layout and shared types of the key/value table
// no dependencies
`default_nettype none

package kvt_pkg;

	localparam int DATA_W          = 32;
	localparam int WORD_W          = 1 + 2 * DATA_W;
	localparam int DEFAULT_ENTRIES = 16;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_IN_USE    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// table word: valid mark on top, then key, then value
	typedef struct packed {
		logic                     valid;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} slot_word_t;

	typedef struct packed {
		logic hit;
		logic free;
	} match_flags_t;

endpackage

`default_nettype wire

### rtl/kvt_ram.sv
// kvt_ram: generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/kvt_match.sv
// kvt_match: compare unit, checks one table word per cycle against the request key
// and keeps the first hit and the lowest free slot; depends on kvt_pkg
`default_nettype none

module kvt_match
	import kvt_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clr,
	input  wire logic                       en,
	input  wire logic [$clog2(ENTRIES)-1:0] idx,
	input  wire slot_word_t                 rd_word,
	input  wire logic [DATA_W-1:0]          key_req,
	output match_flags_t                    flags,
	output logic [$clog2(ENTRIES)-1:0]      hit_idx,
	output logic [$clog2(ENTRIES)-1:0]      free_idx,
	output logic [DATA_W-1:0]               hit_value
);

	localparam int IW = $clog2(ENTRIES);

	match_flags_t      flags_q;
	logic [IW-1:0]     hit_idx_q;
	logic [IW-1:0]     free_idx_q;
	logic [DATA_W-1:0] hit_value_q;
	logic              is_hit;
	logic              is_free;

	assign is_hit  = en && rd_word.valid && (rd_word.key == key_req);
	assign is_free = en && !rd_word.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else begin
			if (is_hit && !flags_q.hit) begin
				flags_q.hit <= 1'b1;
			end
			if (is_free && !flags_q.free) begin
				flags_q.free <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && is_hit && !flags_q.hit) begin
			hit_idx_q   <= idx;
			hit_value_q <= rd_word.value;
		end
		if (!clr && is_free && !flags_q.free) begin
			free_idx_q <= idx;
		end
	end

	assign flags     = flags_q;
	assign hit_idx   = hit_idx_q;
	assign free_idx  = free_idx_q;
	assign hit_value = hit_value_q;

endmodule

`default_nettype wire

### rtl/key_value_table.sv
// key_value_table: top level, request sequencer, table ram and compare unit
// depends on kvt_pkg, kvt_ram, kvt_match
//
// usage
// - input channel in_valid/in_ready carries one request word: action, key, value
// - output channel out_valid/out_ready carries one result word: status, found_value
// - every request gives exactly one result, in request order
// - a request runs from acceptance to a registered result through the states
//   S_SCAN, S_EVAL and S_DECIDE: one table read a cycle through the single
//   ram read port, then the last read data, then decide and write
// - in_ready is high only while no request is in work; one request at a time,
//   so a new request is taken only once the last one has left S_DECIDE
// - results sit in an output register; the next request is taken while a result
//   waits, but its own result is held back until the waiting one is taken
// - after reset the table ram is cleared one slot a cycle with in_ready low;
//   all slots are then empty
// - insert uses the lowest free slot; a present key wins over table full
`default_nettype none

module key_value_table
	import kvt_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               action,
	input  wire logic signed [DATA_W-1:0] key,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      found_value
);

	localparam int            IW   = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_DECIDE
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     addr_q;
	logic [IW-1:0]     rd_idx_q;
	logic              issue_q;
	logic [1:0]        act_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] val_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] found_value_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	slot_word_t        ram_wdata;
	slot_word_t        ram_rdata;

	match_flags_t      flags;
	logic [IW-1:0]     hit_idx;
	logic [IW-1:0]     free_idx;
	logic [DATA_W-1:0] hit_value;

	logic              accept;
	logic              out_free;
	logic [1:0]        status_d;
	logic [DATA_W-1:0] found_d;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	kvt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	kvt_match #(
		.ENTRIES (ENTRIES)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (accept),
		.en        (issue_q),
		.idx       (rd_idx_q),
		.rd_word   (ram_rdata),
		.key_req   (key_q),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.free_idx  (free_idx),
		.hit_value (hit_value)
	);

	// result and table update
	always_comb begin
		status_d  = ST_NOT_FOUND;
		found_d   = '0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		case (act_q)
			ACT_LOOKUP: begin
				if (flags.hit) begin
					status_d = ST_OK;
					found_d  = hit_value;
				end
			end
			ACT_INSERT: begin
				if (flags.hit) begin
					status_d = ST_IN_USE;
				end else if (flags.free) begin
					status_d  = ST_OK;
					ram_we    = (state_q == S_DECIDE) && out_free;
					ram_waddr = free_idx;
					ram_wdata = '{valid: 1'b1, key: key_q, value: val_q};
				end else begin
					status_d = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				if (flags.hit) begin
					status_d  = ST_OK;
					ram_we    = (state_q == S_DECIDE) && out_free;
					ram_waddr = hit_idx;
					ram_wdata = '{valid: 1'b0, key: key_q, value: val_q};
				end
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DECIDE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					issue_q <= 1'b1;
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= S_EVAL;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_EVAL: begin
					issue_q <= 1'b0;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key;
			val_q <= value;
		end
		rd_idx_q <= addr_q;
		if (state_q == S_DECIDE && out_free) begin
			status_q      <= status_d;
			found_value_q <= found_d;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;

	a_match_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !flags.hit && !flags.free)
		else $error("compare unit not cleared for new request");

	a_no_read_at_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECIDE |-> !issue_q)
		else $error("table read still in flight at decision");

	a_insert_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q == S_DECIDE && act_q == ACT_INSERT |-> !flags.hit)
		else $error("insert written over a present key");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DECIDE))
		else $error("result word raised outside decision step");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN || state_q == S_EVAL |-> !ram_we)
		else $error("table written during scan");

endmodule

`default_nettype wire

### sim/tb_key_value_table.sv
`timescale 1ns / 100ps
// tb_key_value_table: self-checking testbench for the key/value table, with a table mirror,
// a request driver with random gaps and random result stalls, and a result monitor
// depends on kvt_pkg and key_value_table

module tb_key_value_table;
	import kvt_pkg::*;

	localparam int          SLOTS       = DEFAULT_ENTRIES;
	localparam int          POOL_SIZE   = 24;
	localparam int          PHASE_WORDS = 500;
	localparam int          CHUNK       = 50;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          DRAIN_WAIT  = 2 * SLOTS + 8;
	localparam int          MAX_REPORTS = 10;
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;

	typedef struct {
		logic [1:0]        act;
		logic [DATA_W-1:0] k;
		logic [DATA_W-1:0] v;
	} request_t;

	typedef struct {
		logic [1:0]        status;
		logic [DATA_W-1:0] found_value;
	} answer_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               action = ACT_LOOKUP;
	logic signed [DATA_W-1:0] key = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] found_value;

	request_t          request_fifo[$];
	answer_t           answers_due[$];
	logic              mirror_valid[SLOTS];
	logic [DATA_W-1:0] mirror_key[SLOTS];
	logic [DATA_W-1:0] mirror_value[SLOTS];
	logic [DATA_W-1:0] key_pool[POOL_SIZE];
	bit                word_taken = 1'b0;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                fail_count = 0;
	int                cycle_count = 0;

	key_value_table #(.ENTRIES(SLOTS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_value (found_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mirror of the table: answer one request and update the slots
	function automatic answer_t apply_request(input logic [1:0] act, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v);
		int      hit;
		int      gap;
		answer_t r;
		hit = SLOTS;
		gap = SLOTS;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit == SLOTS && mirror_valid[i] && mirror_key[i] == k)
				hit = i;
			if (gap == SLOTS && !mirror_valid[i])
				gap = i;
		end
		r.status = ST_NOT_FOUND;
		r.found_value = '0;
		case (act)
			ACT_LOOKUP: begin
				if (hit < SLOTS) begin
					r.status = ST_OK;
					r.found_value = mirror_value[hit];
				end
			end
			ACT_INSERT: begin
				if (hit < SLOTS) begin
					r.status = ST_IN_USE;
				end else if (gap < SLOTS) begin
					mirror_valid[gap] = 1'b1;
					mirror_key[gap] = k;
					mirror_value[gap] = v;
					r.status = ST_OK;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				if (hit < SLOTS) begin
					mirror_valid[hit] = 1'b0;
					r.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic push_request(input logic [1:0] act, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v);
		request_t rq;
		rq.act = act;
		rq.k = k;
		rq.v = v;
		request_fifo.insert(request_fifo.size(), rq);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// random words: keys mostly from a small pool so that hits, full table and
	// refusals are common; insert bias changes by chunk to fill and drain the table
	task automatic queue_random(input int count);
		int               insert_pct;
		int               roll;
		logic [1:0]       act;
		logic [DATA_W-1:0] k;
		insert_pct = 40;
		for (int n = 0; n < count; n++) begin
			if (n % CHUNK == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 70;
					1: insert_pct = 40;
					default: insert_pct = 15;
				endcase
				for (int j = 0; j < 4; j++)
					key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
			end
			roll = $urandom_range(99);
			if (roll < insert_pct)
				act = ACT_INSERT;
			else if (roll < insert_pct + (95 - insert_pct) / 2)
				act = ACT_LOOKUP;
			else if (roll < 95)
				act = ACT_REMOVE;
			else
				act = ACT_UNUSED;
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom;
			push_request(act, k, pick_value());
		end
	endtask

	task automatic wait_idle();
		wait (request_fifo.size() == 0 && !in_valid && answers_due.size() == 0);
		@(posedge clk);
	endtask

	// acceptance of a request word
	always @(posedge clk) begin
		word_taken = arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			answers_due.insert(answers_due.size(), apply_request(action, key, value));
		end
	end

	// request driver and result back-pressure
	always @(negedge clk) begin : drive
		request_t rq;
		if (arst_n && !(in_valid && !word_taken)) begin
			if (request_fifo.size() > 0 && $urandom_range(99) >= idle_pct) begin
				rq = request_fifo.pop_front();
				in_valid <= 1'b1;
				action <= rq.act;
				key <= rq.k;
				value <= rq.v;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// result monitor
	always @(posedge clk) begin : watch
		answer_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result word: status %0d value %h", status, found_value);
			end else begin
				exp = answers_due.pop_front();
				if (status !== exp.status || found_value !== exp.found_value) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: status exp %0d got %0d, value exp %h got %h",
							exp.status, status, exp.found_value, found_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			mirror_valid[i] = 1'b0;
			mirror_key[i] = '0;
			mirror_value[i] = '0;
		end
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed words
		push_request(ACT_LOOKUP, 32'h8000_0000, 32'h0);
		push_request(ACT_REMOVE, 32'h7fff_ffff, 32'h0);
		push_request(ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		push_request(ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000);
		push_request(ACT_INSERT, 32'h0000_0000, 32'hffff_ffff);
		push_request(ACT_LOOKUP, 32'h8000_0000, 32'h1234_5678);
		push_request(ACT_LOOKUP, 32'h7fff_ffff, 32'h0);
		push_request(ACT_LOOKUP, 32'h0000_0000, 32'h0);
		push_request(ACT_INSERT, 32'h8000_0000, 32'h5555_5555);
		push_request(ACT_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
		push_request(ACT_REMOVE, 32'h8000_0000, 32'h0);
		push_request(ACT_REMOVE, 32'h8000_0000, 32'h0);
		push_request(ACT_LOOKUP, 32'h8000_0000, 32'h0);
		// refill the freed lowest slot, then a lookup of a key one bit away
		push_request(ACT_INSERT, 32'hffff_ffff, 32'h0000_0001);
		push_request(ACT_LOOKUP, 32'hffff_fffe, 32'h0);
		push_request(ACT_LOOKUP, 32'hffff_ffff, 32'h0);
		// fill the table, then insert new and present keys into it
		for (int i = 0; i < SLOTS - 3; i++)
			push_request(ACT_INSERT, 32'h1000_0000 + i, $urandom);
		push_request(ACT_INSERT, 32'h0bad_0001, 32'h0);
		push_request(ACT_INSERT, 32'h7fff_ffff, 32'h0);
		wait_idle();

		idle_pct = 0;
		stall_pct = 0;
		queue_random(PHASE_WORDS);
		wait_idle();

		idle_pct = 47;
		stall_pct = 0;
		queue_random(PHASE_WORDS);
		wait_idle();

		idle_pct = 0;
		stall_pct = 47;
		queue_random(PHASE_WORDS);
		wait_idle();

		idle_pct = 34;
		stall_pct = 34;
		queue_random(PHASE_WORDS);
		wait_idle();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
